[rtl/core/orol_pkg.sv]
// shared types and constants for the overwriting ring offset locator
`default_nettype none
package orol_pkg;

    localparam int LEN_W    = 16;
    localparam int HANDLE_W = 32;
    localparam int OFFSET_W = 20;
    localparam int OSLOT_W  = 6;

    // operation codes
    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_FIND = 1'b1;

    typedef struct packed {
        logic                opcode;
        logic [LEN_W-1:0]    record_length;
        logic [HANDLE_W-1:0] record_handle;
        logic [OFFSET_W-1:0] text_offset;
    } req_t;

    typedef struct packed {
        logic                found;
        logic [OSLOT_W-1:0]  found_slot;
        logic [HANDLE_W-1:0] found_handle;
        logic [LEN_W-1:0]    byte_in_record;
        logic                evicted;
        logic [HANDLE_W-1:0] evicted_handle;
    } rsp_t;

    // one stored record
    typedef struct packed {
        logic [LEN_W-1:0]    length;
        logic [HANDLE_W-1:0] handle;
    } rec_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD_RD,
        ST_ADD_WR,
        ST_FIND,
        ST_RESP
    } state_t;

endpackage
`default_nettype wire

[rtl/core/orol_mem.sv]
// record store: one write port, one registered read port, per-entry valid bits
`default_nettype none
module orol_mem #(
    parameter int ENTRIES = 10
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        wr_en,
    input  wire logic [$clog2(ENTRIES)-1:0]  wr_addr,
    input  wire orol_pkg::rec_t              wr_data,
    input  wire logic                        rd_en,
    input  wire logic [$clog2(ENTRIES)-1:0]  rd_addr,
    output      orol_pkg::rec_t              rd_data
);
    import orol_pkg::*;

    rec_t               mem [ENTRIES];
    logic [ENTRIES-1:0] valid_reg;
    rec_t               rd_data_reg;
    logic               rd_valid_reg;

    // storage array, no reset
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // valid bits make the length store read as zero after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    // unwritten entry shows zero length
    always_comb
    begin
        rd_data        = rd_data_reg;
        rd_data.length = rd_valid_reg ? rd_data_reg.length : '0;
    end

endmodule
`default_nettype wire

[rtl/core/orol_ctrl.sv]
// sequencer: slot pointers, add read-modify-write and the find walk
`default_nettype none
module orol_ctrl #(
    parameter int ENTRIES = 10
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        req_valid,
    output      logic                        req_ready,
    input  wire orol_pkg::req_t              req,
    output      logic                        res_valid,
    input  wire logic                        res_ready,
    output      orol_pkg::rsp_t              res,
    output      logic                        wr_en,
    output      logic [$clog2(ENTRIES)-1:0]  wr_addr,
    output      orol_pkg::rec_t              wr_data,
    output      logic                        rd_en,
    output      logic [$clog2(ENTRIES)-1:0]  rd_addr,
    input  wire orol_pkg::rec_t              rd_data
);
    import orol_pkg::*;

    localparam int SLOT_W = $clog2(ENTRIES);
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int ACC_W  = LEN_W + $clog2(ENTRIES);
    localparam int CMP_W  = ((ACC_W > OFFSET_W) ? ACC_W : OFFSET_W) + 1;

    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
        logic [SLOT_W-1:0] r;
        if (s == SLOT_W'(ENTRIES - 1))
            r = '0;
        else
            r = s + SLOT_W'(1);
        return r;
    endfunction

    state_t             state_reg, state_next;
    logic [SLOT_W-1:0]  write_slot_reg, write_slot_next;
    logic [SLOT_W-1:0]  read_slot_reg, read_slot_next;
    logic               ring_full_reg, ring_full_next;
    req_t               item_reg, item_next;
    logic [SLOT_W-1:0]  issue_slot_reg, issue_slot_next;
    logic [CNT_W-1:0]   issue_left_reg, issue_left_next;
    logic               pend_reg, pend_next;
    logic [SLOT_W-1:0]  pend_slot_reg, pend_slot_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    rsp_t               res_reg, res_next;

    logic [CNT_W-1:0]   count;
    logic [ACC_W-1:0]   sum;
    logic [SLOT_W-1:0]  wnext;
    logic [SLOT_W-1:0]  rnext;
    logic [CMP_W-1:0]   diff;

    // number of stored records
    always_comb
    begin
        if (ring_full_reg)
            count = CNT_W'(ENTRIES);
        else if (write_slot_reg >= read_slot_reg)
            count = CNT_W'(write_slot_reg) - CNT_W'(read_slot_reg);
        else
            count = CNT_W'(write_slot_reg) + CNT_W'(ENTRIES) - CNT_W'(read_slot_reg);
    end

    assign sum  = acc_reg + ACC_W'(rd_data.length);
    assign diff = CMP_W'(item_reg.text_offset) - CMP_W'(acc_reg);

    // state and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            write_slot_reg <= '0;
            read_slot_reg  <= '0;
            ring_full_reg  <= 1'b0;
            pend_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            write_slot_reg <= write_slot_next;
            read_slot_reg  <= read_slot_next;
            ring_full_reg  <= ring_full_next;
            pend_reg       <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg       <= item_next;
        issue_slot_reg <= issue_slot_next;
        issue_left_reg <= issue_left_next;
        pend_slot_reg  <= pend_slot_next;
        acc_reg        <= acc_next;
        res_reg        <= res_next;
    end

    // next state and outputs
    always_comb
    begin
        state_next      = state_reg;
        write_slot_next = write_slot_reg;
        read_slot_next  = read_slot_reg;
        ring_full_next  = ring_full_reg;
        item_next       = item_reg;
        issue_slot_next = issue_slot_reg;
        issue_left_next = issue_left_reg;
        pend_next       = 1'b0;
        pend_slot_next  = pend_slot_reg;
        acc_next        = acc_reg;
        res_next        = res_reg;
        req_ready       = 1'b0;
        res_valid       = 1'b0;
        wr_en           = 1'b0;
        wr_addr         = write_slot_reg;
        wr_data         = '{length: item_reg.record_length, handle: item_reg.record_handle};
        rd_en           = 1'b0;
        rd_addr         = write_slot_reg;
        wnext           = next_slot(write_slot_reg);
        rnext           = next_slot(read_slot_reg);

        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    item_next = req;
                    res_next  = '0;
                    if (req.opcode == OP_ADD)
                    begin
                        state_next = ST_ADD_RD;
                    end
                    else if (count == '0)
                    begin
                        state_next = ST_RESP;
                    end
                    else
                    begin
                        issue_slot_next = read_slot_reg;
                        issue_left_next = count;
                        acc_next        = '0;
                        state_next      = ST_FIND;
                    end
                end
            end

            // fetch the record about to be overwritten
            ST_ADD_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = write_slot_reg;
                state_next = ST_ADD_WR;
            end

            ST_ADD_WR:
            begin
                wr_en = 1'b1;
                if (ring_full_reg)
                begin
                    res_next.evicted        = 1'b1;
                    res_next.evicted_handle = rd_data.handle;
                    read_slot_next          = rnext;
                    ring_full_next          = (wnext == rnext);
                end
                else
                begin
                    ring_full_next = (wnext == read_slot_reg);
                end
                write_slot_next = wnext;
                state_next      = ST_RESP;
            end

            // one read issued and one length checked per cycle
            ST_FIND:
            begin
                if (issue_left_reg != '0)
                begin
                    rd_en           = 1'b1;
                    rd_addr         = issue_slot_reg;
                    issue_slot_next = next_slot(issue_slot_reg);
                    issue_left_next = issue_left_reg - CNT_W'(1);
                    pend_next       = 1'b1;
                    pend_slot_next  = issue_slot_reg;
                end
                if (pend_reg)
                begin
                    if (CMP_W'(sum) > CMP_W'(item_reg.text_offset))
                    begin
                        res_next.found          = 1'b1;
                        res_next.found_slot     = OSLOT_W'(pend_slot_reg);
                        res_next.found_handle   = rd_data.handle;
                        res_next.byte_in_record = diff[LEN_W-1:0];
                        pend_next               = 1'b0;
                        state_next              = ST_RESP;
                    end
                    else
                    begin
                        acc_next = sum;
                        if (issue_left_reg == '0)
                        begin
                            state_next = ST_RESP;
                        end
                    end
                end
            end

            ST_RESP:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign res = res_reg;

endmodule
`default_nettype wire

[rtl/core/overwriting_ring_offset_locator_unit.sv]
// top level: record store, sequencer and output register
//
// Ring of ENTRIES records (length, handle). An add transaction stores a record
// at the write slot; once the ring is full it overwrites the oldest record and
// returns its handle as evicted_handle. A find transaction locates text_offset
// within the stored records taken oldest first and returns slot, handle and
// byte position, or found = 0. Each request transaction produces exactly one
// response transaction. An add reads the record at the write slot, then writes
// the new one and loads the response register. A find walks the stored records
// (at most ENTRIES) over the single read port of the record store, one stored
// length per cycle, and ends early at the matching record; a find on an empty
// ring goes straight to the response.
// One request is in progress at a time; a finished response waits in the
// output register so the next request can be taken meanwhile.
`default_nettype none
module overwriting_ring_offset_locator_unit #(
    parameter int ENTRIES = 10
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            req_valid,
    output      logic            req_ready,
    input  wire orol_pkg::req_t  req,
    output      logic            rsp_valid,
    input  wire logic            rsp_ready,
    output      orol_pkg::rsp_t  rsp
);
    import orol_pkg::*;

    localparam int SLOT_W = $clog2(ENTRIES);

    logic              res_valid;
    logic              res_ready;
    rsp_t              res;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    rec_t              wr_data;
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    rec_t              rd_data;
    logic              rsp_valid_reg;
    rsp_t              rsp_reg;

    orol_ctrl #(.ENTRIES(ENTRIES)) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    orol_mem #(.ENTRIES(ENTRIES)) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // output register takes a result whenever it is empty or being drained
    assign res_ready = !rsp_valid_reg || rsp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            rsp_reg <= res;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
`default_nettype wire
